/* rtl/ttc_pkg.sv */
// ttc_pkg: shared types, constants and helpers for terminal_text_cleaner.
// No dependencies; used by every module of the block.
package ttc_pkg;

  localparam int QUEUE_DEPTH = 4;

  // byte codes
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CSI_FIN_LO = 8'h40;
  localparam logic [7:0] CSI_FIN_HI = 8'h7E;
  localparam logic [7:0] CONT_LO  = 8'h80;
  localparam logic [7:0] CONT_HI  = 8'hBF;

  typedef enum logic [2:0] {
    ESC_TEXT    = 3'd0,
    ESC_START   = 3'd1,
    ESC_CSI     = 3'd2,
    ESC_OSC     = 3'd3,
    ESC_OSC_ESC = 3'd4
  } esc_phase_t;

  // One queued burst: rep_cnt replacement characters, then lit_cnt literal bytes.
  typedef struct packed {
    logic [2:0]      rep_cnt;
    logic [2:0]      lit_cnt;
    logic [3:0][7:0] lit;
  } cmd_t;

  // Byte sub of the U+FFFD encoding EF BF BD.
  function automatic logic [7:0] repl_byte(input logic [1:0] sub);
    logic [7:0] b;
    case (sub)
      2'd0:    b = 8'hEF;
      2'd1:    b = 8'hBF;
      default: b = 8'hBD;
    endcase
    return b;
  endfunction

  // Announced UTF-8 length of a lead byte, 0 for a bad lead.
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] n;
    if ((c & 8'hE0) == 8'hC0)      n = 3'd2;
    else if ((c & 8'hF0) == 8'hE0) n = 3'd3;
    else if ((c & 8'hF8) == 8'hF0) n = 3'd4;
    else                           n = 3'd0;
    return n;
  endfunction

endpackage

/* rtl/ttc_front.sv */
// ttc_front: input side; escape stripping, control filtering, UTF-8 tracking.
// Emits one burst command per byte that produces output. Depends on ttc_pkg.
module ttc_front import ttc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       q_full,
  output logic       push,
  output cmd_t       cmd
);

  esc_phase_t phase, phase_next;
  logic [1:0] held_count, held_count_next;
  logic [2:0] seq_len, seq_len_next;
  logic [2:0][7:0] held_bytes;
  logic       held_we;
  logic [1:0] held_idx;
  logic       accept;
  logic [7:0] b;
  logic       is_cont;
  logic [2:0] len;
  logic       emits;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign b        = s_tdata;
  assign is_cont  = (b >= CONT_LO) && (b <= CONT_HI);
  assign len      = lead_len(b);

  always_comb begin
    phase_next      = phase;
    held_count_next = held_count;
    seq_len_next    = seq_len;
    held_we         = 1'b0;
    held_idx        = held_count;
    cmd             = '0;
    unique case (phase)
      ESC_START: begin
        if (b == CH_LBRK)      phase_next = ESC_CSI;
        else if (b == CH_RBRK) phase_next = ESC_OSC;
        else                   phase_next = ESC_TEXT;
      end
      ESC_CSI: begin
        if (b >= CSI_FIN_LO && b <= CSI_FIN_HI) phase_next = ESC_TEXT;
      end
      ESC_OSC: begin
        if (b == CH_BEL)      phase_next = ESC_TEXT;
        else if (b == CH_ESC) phase_next = ESC_OSC_ESC;
      end
      ESC_OSC_ESC: begin
        phase_next = (b == CH_BSL) ? ESC_TEXT : ESC_OSC;
      end
      default: begin
        phase_next = ESC_TEXT;
        if (b == CH_ESC) begin
          phase_next = ESC_START;
        end else if (b == CH_LF) begin
          // truncated sequence at line end
          cmd.rep_cnt     = {1'b0, held_count};
          cmd.lit[0]      = CH_LF;
          cmd.lit_cnt     = 3'd1;
          held_count_next = '0;
          seq_len_next    = '0;
        end else if (b == CH_TAB || (b >= CH_SPACE && b != CH_DEL)) begin
          if (held_count != 2'd0 && is_cont) begin
            if ({1'b0, held_count} + 3'd1 >= seq_len) begin
              // sequence complete: held bytes then this one
              for (int k = 0; k < 3; k++) begin
                if (2'(k) < held_count) cmd.lit[2'(k)] = held_bytes[2'(k)];
                else                    cmd.lit[2'(k)] = b;
              end
              cmd.lit[3]      = b;
              cmd.lit_cnt     = {1'b0, held_count} + 3'd1;
              held_count_next = '0;
              seq_len_next    = '0;
            end else begin
              held_we         = 1'b1;
              held_count_next = held_count + 2'd1;
            end
          end else begin
            // broken sequence flush (if any), then handle the byte afresh
            cmd.rep_cnt     = {1'b0, held_count};
            held_count_next = '0;
            seq_len_next    = '0;
            if (b < CONT_LO) begin
              cmd.lit[0]  = b;
              cmd.lit_cnt = 3'd1;
            end else if (len == 3'd0) begin
              cmd.rep_cnt = {1'b0, held_count} + 3'd1;
            end else begin
              held_we         = 1'b1;
              held_idx        = 2'd0;
              held_count_next = 2'd1;
              seq_len_next    = len;
            end
          end
        end
      end
    endcase
  end

  assign emits = (cmd.rep_cnt != 3'd0) || (cmd.lit_cnt != 3'd0);
  assign push  = accept && emits;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ESC_TEXT;
      held_count <= '0;
      seq_len    <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      held_count <= held_count_next;
      seq_len    <= seq_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_we) held_bytes[held_idx] <= b;
  end

  // a held run is always shorter than its announced length
  a_held_fits: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd0 |-> (seq_len >= 3'd2 && seq_len <= 3'd4 &&
                            {1'b0, held_count} < seq_len))
    else $error("held byte count out of range");

  // nothing leaves the front while an escape is being swallowed
  a_esc_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && (phase == ESC_START || phase == ESC_CSI ||
                phase == ESC_OSC || phase == ESC_OSC_ESC)) |-> !push)
    else $error("output produced inside an escape");

endmodule

/* rtl/ttc_fifo.sv */
// ttc_fifo: short command queue between front and back.
// Depends on ttc_pkg for cmd_t.
module ttc_fifo import ttc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic full,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full   = (count == DEPTH_C);
  assign empty  = (count == '0);
  assign rd_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");

endmodule

/* rtl/ttc_back.sv */
// ttc_back: output side; expands queued burst commands into output beats.
// Depends on ttc_pkg.
module ttc_back import ttc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  cmd_t       q_cmd,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast    // last
);

  logic       busy;
  cmd_t       cur;
  logic [2:0] rep_left;
  logic [1:0] sub;
  logic [2:0] lit_idx;
  logic       step, fin, load;
  logic [7:0] beat_byte;

  assign step = busy && (!m_tvalid || m_tready);
  assign fin  = (rep_left == 3'd0) ? (lit_idx + 3'd1 == cur.lit_cnt)
                                   : (rep_left == 3'd1 && sub == 2'd2 &&
                                      cur.lit_cnt == 3'd0);
  assign load = (!busy || (step && fin)) && !q_empty;
  assign pop  = load;
  assign beat_byte = (rep_left != 3'd0) ? repl_byte(sub) : cur.lit[lit_idx[1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load)            busy <= 1'b1;
      else if (step && fin) busy <= 1'b0;
      if (step)          m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= beat_byte;
      m_tlast <= fin;
    end
    if (load) begin
      cur      <= q_cmd;
      rep_left <= q_cmd.rep_cnt;
      sub      <= '0;
      lit_idx  <= '0;
    end else if (step) begin
      if (rep_left != 3'd0) begin
        if (sub == 2'd2) begin
          sub      <= '0;
          rep_left <= rep_left - 3'd1;
        end else begin
          sub <= sub + 2'd1;
        end
      end else begin
        lit_idx <= lit_idx + 3'd1;
      end
    end
  end

  // a burst in progress never runs past its literal count
  a_lit_bound: assert property (@(posedge clk) disable iff (rst)
    (busy && rep_left == 3'd0) |-> (lit_idx < cur.lit_cnt))
    else $error("literal index past burst end");

endmodule

/* rtl/terminal_text_cleaner.sv */
// terminal_text_cleaner: top level; front classifier, command queue, back expander.
// Depends on ttc_pkg, ttc_front, ttc_fifo, ttc_back.
//
//  channel   dir  tdata            tlast  tuser
//  s_axis    in   [7:0] in_byte    -      -
//  m_axis    out  [7:0] out_byte   last   -
//
// The front takes one byte per cycle whenever the command queue has room.
// The back sends one output beat per cycle while it has beats and m_tready holds;
// a byte can cause up to 12 output beats, so input stalls only when bursts
// outrun the output port and fill the QueueDepth-entry queue.
// The first output beat of a byte passes the queue, then the load into the
// back, then the output register.
// Reset (rst, synchronous) clears escape phase, UTF-8 state, queue and output.
module terminal_text_cleaner import ttc_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast    // last result of the input beat
);

  cmd_t front_cmd, back_cmd;
  logic push, pop, q_full, q_empty;

  // escape strip + UTF-8 checks, one command per producing byte
  ttc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .cmd      (front_cmd)
  );

  // decouples the input, one byte per cycle while the queue has room, from multi-beat bursts
  ttc_fifo #(
    .DEPTH (QueueDepth)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (front_cmd),
    .pop    (pop),
    .rd_cmd (back_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  // replacement characters first, then literal bytes; tlast on the final beat
  ttc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_cmd    (back_cmd),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
